[rtl/wpd_pkg.sv]
// Shared constants for the waveform peak decimator.
package wpd_pkg;

    // Width of the per-track sample counter and of the block size register
    localparam int COUNT_BITS = 16;

    // Block size after reset
    localparam logic [COUNT_BITS-1:0] BLOCK_SIZE_RESET = 16'd1024;

    // Item kinds carried on the action field
    typedef enum logic
    {
        ACTION_SAMPLE = 1'b0,
        ACTION_FLUSH  = 1'b1
    } action_t;

endpackage

[rtl/wpd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wpd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/waveform_peak_decimator_unit.sv]
// Waveform peak decimator: min/max decimation of per-track audio into peak blocks.
//
// Each input item is either one signed sample for a track or a flush request
// for that track. Per track the unit keeps a running minimum, a running
// maximum and a sample count in one small RAM (one entry per track). The
// first sample of a block sets both extremes; when the count reaches
// block_size one item goes out with the block's min/max and partial = 0, and
// the count restarts. A flush of an open block sends it out with partial = 1;
// a flush of an empty block, and any item whose track is TRACKS or above,
// produces nothing. A block size of zero behaves as one.
// Throughput: one item per clock, sustained, on any mix of tracks, while the
// output register is not stalled. An accepted item has its state read from
// the RAM as it is accepted; in the update stage it is updated, written back
// and its result, if any, is loaded into the output register. A write forwarding
// register covers an item that hits the same track as the item just ahead
// of it. in_stall rises only while the update stage holds a result that the
// full, stalled output register cannot take. No clearing pass after reset:
// a per-track valid flag marks entries never written, which read as empty.
// block_size may only be written while no item is in flight.
module waveform_peak_decimator_unit #(
    parameter int TRACKS      = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // configuration: block size
    input  logic                          cfg_wr_en,
    input  logic [wpd_pkg::COUNT_BITS-1:0] cfg_wr_data,

    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [2:0]                    track,
    input  logic signed [SAMPLE_BITS-1:0] sample,

    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    out_track,
    output logic signed [SAMPLE_BITS-1:0] block_min,
    output logic signed [SAMPLE_BITS-1:0] block_max,
    output logic                          partial
);

    localparam int CB = wpd_pkg::COUNT_BITS;
    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    // entry layout: {count, max, min}
    localparam int EW = CB + 2 * SAMPLE_BITS;

    // config register
    logic [CB-1:0] block_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= wpd_pkg::BLOCK_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            block_size_reg <= cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------
    // Accept / RAM read
    // ---------------------------------------------------------------
    logic          in_accept;
    logic          track_ok;
    logic          enter;
    logic [TW-1:0] in_addr;

    assign in_accept = in_valid && !in_stall;
    assign track_ok  = (int'(track) < TRACKS);
    assign enter     = in_accept && track_ok;
    assign in_addr   = TW'(track);

    // update stage registers
    logic                          s1_valid_reg;
    logic                          s1_flush_reg;
    logic [TW-1:0]                 s1_addr_reg;
    logic [2:0]                    s1_track_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;

    // last write, for same-track back-to-back items
    logic          fwd_valid_reg;
    logic [TW-1:0] fwd_addr_reg;
    logic [EW-1:0] fwd_data_reg;

    // entries written at least once
    logic [TRACKS-1:0] written_reg;

    logic          wr_en;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] rd_data;

    wpd_ram #(
        .WIDTH (EW),
        .DEPTH (TRACKS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data),
        .rd_en   (enter),
        .rd_addr (in_addr),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------
    // Read-modify-write stage
    // ---------------------------------------------------------------
    logic [EW-1:0]                 cur;
    logic [CB-1:0]                 cur_count;
    logic signed [SAMPLE_BITS-1:0] cur_min;
    logic signed [SAMPLE_BITS-1:0] cur_max;
    logic                          cur_empty;
    logic signed [SAMPLE_BITS-1:0] new_min;
    logic signed [SAMPLE_BITS-1:0] new_max;
    logic [CB-1:0]                 count_inc;
    logic                          block_full;
    logic                          s1_emit;
    logic                          s1_partial;
    logic                          s1_go;
    logic                          out_free;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cur = fwd_data_reg;
        end
        else if (written_reg[s1_addr_reg])
        begin
            cur = rd_data;
        end
        else
        begin
            cur = '0;
        end
    end

    assign cur_count = cur[EW-1 -: CB];
    assign cur_max   = cur[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
    assign cur_min   = cur[SAMPLE_BITS-1:0];
    assign cur_empty = (cur_count == '0);

    // a new block takes the sample as both extremes
    assign new_min = (cur_empty || (s1_sample_reg < cur_min)) ? s1_sample_reg : cur_min;
    assign new_max = (cur_empty || (s1_sample_reg > cur_max)) ? s1_sample_reg : cur_max;

    // count wraps at 16 bits; a wrap also closes the block
    assign count_inc  = cur_count + CB'(1);
    assign block_full = (count_inc >= block_size_reg) || (count_inc == '0);

    always_comb
    begin
        s1_partial = 1'b0;
        wr_data    = cur;
        case (wpd_pkg::action_t'(s1_flush_reg))
            wpd_pkg::ACTION_SAMPLE:
            begin
                s1_emit = block_full;
                wr_data = {(block_full ? CB'(0) : count_inc), new_max, new_min};
            end
            wpd_pkg::ACTION_FLUSH:
            begin
                s1_emit    = !cur_empty;
                s1_partial = 1'b1;
                wr_data    = {CB'(0), cur_max, cur_min};
            end
            default:
            begin
                s1_emit = 1'b0;
            end
        endcase
    end

    assign out_free = !out_valid || !out_stall;
    assign s1_go    = !s1_emit || out_free;
    assign in_stall = s1_valid_reg && !s1_go;

    // empty flush leaves the entry alone
    assign wr_en = s1_valid_reg && s1_go && (!s1_flush_reg || !cur_empty);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            if (enter)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                fwd_valid_reg            <= 1'b1;
                written_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            s1_flush_reg  <= action;
            s1_addr_reg   <= in_addr;
            s1_track_reg  <= track;
            s1_sample_reg <= sample;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= wr_data;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic                          out_valid_reg;
    logic [2:0]                    out_track_reg;
    logic signed [SAMPLE_BITS-1:0] out_min_reg;
    logic signed [SAMPLE_BITS-1:0] out_max_reg;
    logic                          out_partial_reg;
    logic                          load_out;

    assign load_out = s1_valid_reg && s1_emit && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_track_reg   <= s1_track_reg;
            out_min_reg     <= s1_flush_reg ? cur_min : new_min;
            out_max_reg     <= s1_flush_reg ? cur_max : new_max;
            out_partial_reg <= s1_partial;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_track = out_track_reg;
    assign block_min = out_min_reg;
    assign block_max = out_max_reg;
    assign partial   = out_partial_reg;

endmodule
